// File: src/nig_pkg.sv
// ----------------------------------------------------------------------------
// nig_pkg
// Shared codes, widths and payload types of the neighbor index generator.
// ----------------------------------------------------------------------------
package nig_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_ROW_LENGTH    = 2'd0;
  localparam logic [1:0] REG_COLUMN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SLICE_COUNT   = 2'd2;
  localparam logic [1:0] REG_PLANAR_MODE   = 2'd3;

  // request kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int OFFSET_BITS = 8;
  localparam int SRC_W       = 31;
  localparam int DIM_W       = 16;

  // one neighborhood entry as held in the table
  typedef struct packed {
    logic signed [OFFSET_BITS-1:0] dx;
    logic signed [OFFSET_BITS-1:0] dy;
    logic signed [OFFSET_BITS-1:0] dz;
    logic [SRC_W-1:0]              disp;
  } ent_t;

  // query context carried alongside the division stages
  typedef struct packed {
    logic             ok;
    logic [SRC_W-1:0] src;
    ent_t             ent;
  } qry_t;

  // context through the second division: z quotient plus query context
  typedef struct packed {
    logic [SRC_W-1:0] z0;
    qry_t             qry;
  } qry2_t;

endpackage

// File: src/nig_ram.sv
// ----------------------------------------------------------------------------
// nig_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nig_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/nig_div.sv
// ----------------------------------------------------------------------------
// nig_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module nig_div #(
  parameter int NW = 31,
  parameter int DW = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [SW-1:0] in_side,
  input  logic [DW-1:0] divisor,
  output logic          out_vld,
  output logic [NW-1:0] out_quo,
  output logic [NW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  localparam int CW = ((NW + 1) > DW) ? (NW + 2) : (DW + 1);

  logic          vld_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] rem_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vld_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic [NW:0]   trial;
    logic [CW-1:0] diff;
    logic          ge;

    // stage inputs
    if (s == 0) begin : g_first
      assign vld_in  = in_vld;
      assign num_in  = in_num;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign num_in  = num_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign side_in = side_r[s-1];
    end

    // trial subtract of one quotient bit
    always_comb begin
      trial = {rem_in, num_in[NW-1]};
      ge    = CW'(trial) >= CW'(divisor);
      diff  = CW'(trial) - CW'(divisor);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s]  <= {num_in[NW-2:0], 1'b0};
        rem_r[s]  <= ge ? diff[NW-1:0] : trial[NW-1:0];
        quo_r[s]  <= {quo_in[NW-2:0], ge};
        side_r[s] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_quo  = quo_r[NW-1];
  assign out_rem  = rem_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule

// File: src/neighbor_index_generator_3d_top.sv
// ----------------------------------------------------------------------------
// neighbor_index_generator_3d_top
// Loads neighborhood entries and turns (voxel index, entry) queries into
// bounds-checked neighbor indexes for 2D or 3D images.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tuser: action; tdata: entry, voxel, dx, dy, dz
//  out_     master     out_tvalid/tready    tuser: inside_res; tdata: neighbor_index
//  cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request enters per cycle while out_ does not stall. A query result passes
// through the stage 1 register and the entry table read, 31 stages for the split by
// plane size, 31 for the split by row length and one output register. Loads
// produce no result. A stall on out_ freezes the whole pipeline. Reset clears valid bits,
// sets the sizes to one and 3D mode, and leaves table entries undefined.
// ----------------------------------------------------------------------------
module neighbor_index_generator_3d_top #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // entry_number, voxel_index, offset_x, offset_y, offset_z
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // neighbor_index
  output logic        out_tuser,  // inside_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EW = $bits(nig_pkg::ent_t);
  localparam int QW = $bits(nig_pkg::qry_t);
  localparam int Q2W = $bits(nig_pkg::qry2_t);
  localparam int SW = nig_pkg::SRC_W;
  localparam int OB = nig_pkg::OFFSET_BITS;

  // configuration
  logic [15:0] row_r, col_r, slc_r;
  logic        planar_r;
  logic [31:0] plane_r;
  logic [15:0] row_sel, col_sel;

  assign cfg_ready = 1'b1;

  always_comb begin
    row_sel = (cfg_index == nig_pkg::REG_ROW_LENGTH) ? cfg_data : row_r;
    col_sel = (cfg_index == nig_pkg::REG_COLUMN_HEIGHT) ? cfg_data : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= 16'd1;
      col_r    <= 16'd1;
      slc_r    <= 16'd1;
      planar_r <= 1'b0;
      plane_r  <= 32'd1;
    end else if (cfg_valid) begin
      row_r   <= row_sel;
      col_r   <= col_sel;
      plane_r <= 32'(row_sel) * 32'(col_sel);
      if (cfg_index == nig_pkg::REG_SLICE_COUNT) begin
        slc_r <= cfg_data;
      end
      if (cfg_index == nig_pkg::REG_PLANAR_MODE) begin
        planar_r <= cfg_data[0];
      end
    end
  end

  // pipeline advance: everything moves when the output slot frees
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // input unpacking
  logic [4:0]           in_entry;
  logic [SW-1:0]        in_src;
  logic signed [OB-1:0] in_dx, in_dy, in_dz;
  assign in_entry = in_tdata[4:0];
  assign in_src   = in_tdata[35:5];
  assign in_dx    = in_tdata[43:36];
  assign in_dy    = in_tdata[51:44];
  assign in_dz    = in_tdata[59:52];

  // stage 1: capture request and displacement products
  logic                 s1_vld_r, s1_act_r, s1_ok_r;
  logic [4:0]           s1_entry_r;
  logic [SW-1:0]        s1_src_r;
  logic signed [OB-1:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [OB+16:0] s1_py_r;
  logic signed [OB+32:0] s1_pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_act_r   <= in_tuser;
      s1_ok_r    <= 32'(in_entry) < MAX_ENTRIES;
      s1_entry_r <= in_entry;
      s1_src_r   <= in_src;
      s1_dx_r    <= in_dx;
      s1_dy_r    <= in_dy;
      s1_dz_r    <= in_dz;
      s1_py_r    <= (OB+17)'(in_dy) * (OB+17)'($signed({1'b0, row_r}));
      s1_pz_r    <= (OB+33)'(in_dz) * (OB+33)'($signed({1'b0, plane_r}));
    end
  end

  // entry table: loads write and queries read at the same stage
  logic signed [OB+32:0] disp_sum;
  nig_pkg::ent_t         wr_ent, rd_ent;
  logic [EW-1:0]         rd_word;
  logic                  tbl_we;

  always_comb begin
    disp_sum    = s1_pz_r + (OB+33)'(s1_py_r) + (OB+33)'(s1_dx_r);
    wr_ent.dx   = s1_dx_r;
    wr_ent.dy   = s1_dy_r;
    wr_ent.dz   = s1_dz_r;
    wr_ent.disp = disp_sum[SW-1:0];
    tbl_we      = en && s1_vld_r && (s1_act_r == nig_pkg::ACT_LOAD) && s1_ok_r;
  end

  nig_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(s1_entry_r)),
    .wdata (wr_ent),
    .re    (en),
    .raddr (AW'(s1_entry_r)),
    .rdata (rd_word)
  );
  assign rd_ent = nig_pkg::ent_t'(rd_word);

  // stage 2: query with its entry
  logic          s2_vld_r, s2_ok_r;
  logic [SW-1:0] s2_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r && (s1_act_r == nig_pkg::ACT_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ok_r  <= s1_ok_r;
      s2_src_r <= s1_src_r;
    end
  end

  // split by plane size (planar mode divides by 2^32, leaving z at zero)
  nig_pkg::qry_t q1_in, q1_out;
  logic [QW-1:0] q1_out_w;
  logic [32:0]   div1_d;
  logic          d1_vld;
  logic [SW-1:0] d1_quo, d1_rem;

  always_comb begin
    q1_in.ok  = s2_ok_r;
    q1_in.src = s2_src_r;
    q1_in.ent = rd_ent;
    div1_d    = planar_r ? 33'h1_0000_0000 : {1'b0, plane_r};
  end

  nig_div #(.NW(SW), .DW(33), .SW(QW)) u_div_plane (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_num   (s2_src_r),
    .in_side  (q1_in),
    .divisor  (div1_d),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_rem  (d1_rem),
    .out_side (q1_out_w)
  );
  assign q1_out = nig_pkg::qry_t'(q1_out_w);

  // split by row length
  nig_pkg::qry2_t q2_in, q2_out;
  logic [Q2W-1:0] q2_out_w;
  logic           d2_vld;
  logic [SW-1:0]  x0, y0;

  always_comb begin
    q2_in.z0  = d1_quo;
    q2_in.qry = q1_out;
  end

  nig_div #(.NW(SW), .DW(16), .SW(Q2W)) u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d1_vld),
    .in_num   (d1_rem),
    .in_side  (q2_in),
    .divisor  (row_r),
    .out_vld  (d2_vld),
    .out_quo  (y0),
    .out_rem  (x0),
    .out_side (q2_out_w)
  );
  assign q2_out = nig_pkg::qry2_t'(q2_out_w);

  // bounds check and neighbor index
  logic signed [SW+1:0] nx, ny, nz;
  logic                 in_x, in_y, in_z, nb_inside;
  logic [SW-1:0]        nb_idx;

  always_comb begin
    nx        = $signed({2'b00, x0}) + (SW+2)'(q2_out.qry.ent.dx);
    ny        = $signed({2'b00, y0}) + (SW+2)'(q2_out.qry.ent.dy);
    nz        = $signed({2'b00, q2_out.z0}) + (SW+2)'(q2_out.qry.ent.dz);
    in_x      = !nx[SW+1] && (nx[SW:0] < (SW+1)'(row_r));
    in_y      = !ny[SW+1] && (ny[SW:0] < (SW+1)'(col_r));
    in_z      = !nz[SW+1] && (nz[SW:0] < (SW+1)'(slc_r));
    nb_inside = q2_out.qry.ok && in_x && in_y && (planar_r || in_z);
    nb_idx    = nb_inside ? (q2_out.qry.src + q2_out.qry.ent.disp) : '0;
  end

  // output register
  logic          out_vld_r, out_inside_r;
  logic [SW-1:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside_r <= nb_inside;
      out_idx_r    <= nb_idx;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_inside_r;
  assign out_tdata  = {1'b0, out_idx_r};

  // an outside answer carries a zero index
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 32'd0))
    else $error("outside result with nonzero index");

  // a stalled output freezes the last division stage
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(d2_vld))
    else $error("pipeline moved during stall");

  // loads never reach the division pipeline
  assert property (@(posedge clk) disable iff (!rst_n)
    (en && s1_vld_r && (s1_act_r == nig_pkg::ACT_LOAD)) |=> !s2_vld_r)
    else $error("load entered division pipeline");

  // reset empties the output slot
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the neighbor index generator: loads neighborhood
// entries, sweeps image sizes and 2D/3D mode, and checks every query result
// against an in-bench predictor under random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;
  localparam int SW = nig_pkg::SRC_W;
  localparam int OB = nig_pkg::OFFSET_BITS;

  typedef struct {
    logic          act;
    logic [4:0]    entry;
    logic [SW-1:0] src;
    logic [OB-1:0] dx, dy, dz;
  } voxel_req_t;

  typedef struct {
    logic          in_img;
    logic [SW-1:0] nbr;
  } neighbor_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor copy of the configuration and the entry tables
  longint row_len, col_h, slices, plane;
  logic   planar;
  longint tab_dx [32];
  longint tab_dy [32];
  longint tab_dz [32];
  longint tab_disp [32];

  voxel_req_t pending_reqs[$];
  neighbor_t  expected_nbrs[$];
  voxel_req_t cur_req;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  logic       calm = 1'b0;

  neighbor_index_generator_3d_top u_top (.*);

  always #2 clk = ~clk;

  // apply one accepted request to the predictor
  function automatic void predict_request(voxel_req_t r);
    longint    sx, sy, sz, rem, x, y, z;
    neighbor_t n;
    sx = longint'($signed(r.dx));
    sy = longint'($signed(r.dy));
    sz = longint'($signed(r.dz));
    if (r.act == nig_pkg::ACT_LOAD) begin
      tab_dx[r.entry] = sx;
      tab_dy[r.entry] = sy;
      tab_dz[r.entry] = sz;
      tab_disp[r.entry] = sx + sy * row_len + sz * plane;
      return;
    end
    n.in_img = 1'b0;
    if (row_len != 0 && col_h != 0) begin
      if (planar) begin
        x = longint'(r.src) % row_len + tab_dx[r.entry];
        y = longint'(r.src) / row_len + tab_dy[r.entry];
        n.in_img = x >= 0 && x < row_len && y >= 0 && y < col_h;
      end else if (slices != 0) begin
        rem = longint'(r.src) % plane;
        x = rem % row_len + tab_dx[r.entry];
        y = rem / row_len + tab_dy[r.entry];
        z = longint'(r.src) / plane + tab_dz[r.entry];
        n.in_img = x >= 0 && x < row_len && y >= 0 && y < col_h && z >= 0 && z < slices;
      end
    end
    n.nbr = n.in_img ? SW'(longint'(r.src) + tab_disp[r.entry]) : '0;
    expected_nbrs.push_back(n);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_request(cur_req);
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.act;
          in_tdata <= {4'b0, cur_req.dz, cur_req.dy, cur_req.dx, cur_req.src, cur_req.entry};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    neighbor_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_nbrs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result inside=%0b index=%0d", out_tuser, out_tdata[30:0]);
        end else begin
          e = expected_nbrs.pop_front();
          if (out_tuser !== e.in_img || out_tdata !== {1'b0, e.nbr}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected inside=%0b index=%0d, got inside=%0b index=%0d",
                       e.in_img, e.nbr, out_tuser, out_tdata);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || $urandom_range(0, 99) >= 18;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("neighbor_index_generator_3d_top: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      nig_pkg::REG_ROW_LENGTH:    row_len = val;
      nig_pkg::REG_COLUMN_HEIGHT: col_h = val;
      nig_pkg::REG_SLICE_COUNT:   slices = val;
      default:                    planar = val[0];
    endcase
    plane = row_len * col_h;
  endtask

  task automatic set_image(int rl, int ch, int sc, bit pm);
    write_reg(nig_pkg::REG_ROW_LENGTH, 16'(rl));
    write_reg(nig_pkg::REG_COLUMN_HEIGHT, 16'(ch));
    write_reg(nig_pkg::REG_SLICE_COUNT, 16'(sc));
    write_reg(nig_pkg::REG_PLANAR_MODE, 16'(pm));
  endtask

  // wait until the block holds no work, then let the pipeline empty
  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_nbrs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic voxel_req_t load_req(int e, int x, int y, int z);
    voxel_req_t r;
    r.act = nig_pkg::ACT_LOAD;
    r.entry = 5'(e);
    r.src = SW'($urandom());
    r.dx = 8'(x);
    r.dy = 8'(y);
    r.dz = 8'(z);
    return r;
  endfunction

  function automatic voxel_req_t query_req(int e, longint s);
    voxel_req_t r;
    r.act = nig_pkg::ACT_QUERY;
    r.entry = 5'(e);
    r.src = SW'(s);
    {r.dx, r.dy, r.dz} = 24'($urandom());
    return r;
  endfunction

  // coordinate biased toward the image edges
  function automatic longint pick_coord(longint n);
    if (n <= 0) return 0;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return n - 1;
      default: return longint'($urandom_range(0, 32'(n - 1)));
    endcase
  endfunction

  function automatic int pick_offset();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 6) - 3;
    return $urandom_range(0, 255);
  endfunction

  function automatic voxel_req_t random_req();
    longint s;
    if ($urandom_range(0, 9) < 3)
      return load_req($urandom_range(0, 31), pick_offset(), pick_offset(), pick_offset());
    s = pick_coord(row_len) + pick_coord(col_h) * row_len +
        (planar ? 0 : pick_coord(slices) * plane);
    if ($urandom_range(0, 9) < 2 || s > 64'h7FFF_FFFF) s = $urandom() & 32'h7FFF_FFFF;
    return query_req($urandom_range(0, 31), s);
  endfunction

  task automatic random_phase(int count);
    repeat (count) pending_reqs.push_back(random_req());
  endtask

  initial begin
    row_len = 1;
    col_h = 1;
    slices = 1;
    planar = 1'b0;
    plane = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every entry loaded, extreme offsets, corners, outside cases
    set_image(5, 4, 3, 0);
    for (int e = 0; e < 32; e++)
      pending_reqs.push_back(load_req(e, pick_offset(), pick_offset(), pick_offset()));
    pending_reqs.push_back(load_req(0, -128, -128, -128));
    pending_reqs.push_back(load_req(1, 127, 127, 127));
    pending_reqs.push_back(load_req(2, 0, 0, 0));
    pending_reqs.push_back(load_req(3, 1, 0, 0));
    pending_reqs.push_back(load_req(4, -1, 1, 1));
    pending_reqs.push_back(query_req(2, 0));
    pending_reqs.push_back(query_req(2, 59));
    pending_reqs.push_back(query_req(3, 4));
    pending_reqs.push_back(query_req(3, 3));
    pending_reqs.push_back(query_req(4, 1));
    pending_reqs.push_back(query_req(4, 0));
    pending_reqs.push_back(query_req(0, 59));
    pending_reqs.push_back(query_req(1, 0));
    pending_reqs.push_back(query_req(2, 60));
    pending_reqs.push_back(query_req(2, 32'h7FFF_FFFF));
    random_phase(100);
    drain();

    // stale entries after a size change, then planar mode
    set_image(7, 9, 1, 1);
    pending_reqs.push_back(query_req(3, 5));
    random_phase(150);
    drain();

    // long receiver hold-off while requests keep coming
    set_image(16, 16, 16, 0);
    hold_left <= 400;
    random_phase(200);
    // sender pauses until every result is back
    while (pending_reqs.size() != 0 || in_tvalid || expected_nbrs.size() != 0)
      @(posedge clk);
    random_phase(100);
    drain();

    // a stretch without any idling
    calm <= 1'b1;
    set_image(300, 200, 30, 0);
    random_phase(200);
    drain();
    calm <= 1'b0;

    // size extremes
    set_image(65535, 65535, 65535, 0);
    random_phase(120);
    drain();
    set_image(65535, 1, 1, 1);
    random_phase(120);
    drain();
    set_image(1, 65535, 65535, 1);
    random_phase(120);
    drain();
    set_image(1, 1, 1, 0);
    random_phase(100);
    drain();

    // zero sizes answer outside, except a zero slice count in planar mode
    set_image(0, 5, 5, 0);
    random_phase(40);
    drain();
    set_image(6, 6, 0, 0);
    random_phase(40);
    drain();
    set_image(6, 6, 0, 1);
    random_phase(40);
    drain();

    if (mismatches == 0)
      $display("neighbor_index_generator_3d_top: match");
    else
      $display("neighbor_index_generator_3d_top: mismatch");
    $finish;
  end

endmodule
